[design/qfpl_pkg.sv]
// Shared types and constants for the quad field point locator.
package qfpl_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_C0_X = 3'd0;
    localparam logic [2:0] REG_C0_Y = 3'd1;
    localparam logic [2:0] REG_C1_X = 3'd2;
    localparam logic [2:0] REG_C1_Y = 3'd3;
    localparam logic [2:0] REG_C2_X = 3'd4;
    localparam logic [2:0] REG_C2_Y = 3'd5;
    localparam logic [2:0] REG_C3_X = 3'd6;
    localparam logic [2:0] REG_C3_Y = 3'd7;

    // Dot test threshold, quarter-pixel squared units
    localparam int DOT_LIMIT = -4;

    // Geometry pipeline depth after a config write
    localparam logic [2:0] SETTLE_CYCLES = 3'd4;

    // Coefficient signs per sector, bit k set = negative
    localparam logic [3:0] SGN_X_S_NEG = 4'b0011;
    localparam logic [3:0] SGN_X_T_NEG = 4'b1001;
    localparam logic [3:0] SGN_Y_S_NEG = 4'b1001;
    localparam logic [3:0] SGN_Y_T_NEG = 4'b1100;

    typedef struct packed {
        logic [1:0] sector;
        logic       fallback;
    } meta_t;

    typedef struct packed {
        logic neg_x;
        logic hi_x;
        logic neg_y;
        logic hi_y;
    } range_t;

endpackage

[design/qfpl_geom.sv]
// Corner registers and derived fan geometry (directions, centre sum, determinants).
module qfpl_geom #(
    parameter int COORD_BITS = 12
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write_en,
    input  logic [2:0]                        cfg_index,
    input  logic [COORD_BITS-1:0]             cfg_data,
    output logic                              busy,
    output logic [COORD_BITS+1:0]             sum_x,
    output logic [COORD_BITS+1:0]             sum_y,
    output logic signed [COORD_BITS+2:0]      dir_x [4],
    output logic signed [COORD_BITS+2:0]      dir_y [4],
    output logic signed [2*COORD_BITS+6:0]    det [4]
);
    localparam int CW = COORD_BITS;
    localparam int SW = CW + 2;
    localparam int DW = CW + 3;
    localparam int PW = 2 * DW;
    localparam int AW = PW + 1;
    localparam int EW = CW + 1;
    localparam int QW = 2 * CW + 3;

    logic [CW-1:0] cx_reg [4];
    logic [CW-1:0] cy_reg [4];
    logic [2:0]    settle_reg;

    logic [QW-1:0] d2_next [1:3];
    logic [QW-1:0] d2_reg  [1:3];

    logic [CW-1:0] ox [4];
    logic [CW-1:0] oy [4];
    logic [1:0]    diag;
    logic [QW-1:0] best;
    logic [SW-1:0] sx_next;
    logic [SW-1:0] sy_next;
    logic [SW-1:0] sx_reg;
    logic [SW-1:0] sy_reg;
    logic signed [DW-1:0] dx_reg [4];
    logic signed [DW-1:0] dy_reg [4];
    logic signed [PW-1:0] pa_reg [4];
    logic signed [PW-1:0] pb_reg [4];
    logic signed [AW-1:0] det_reg [4];

    // config registers and settle counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                cx_reg[i] <= '0;
                cy_reg[i] <= '0;
            end
            settle_reg <= qfpl_pkg::SETTLE_CYCLES;
        end
        else
        begin
            if (cfg_write_en)
            begin
                unique case (cfg_index)
                    qfpl_pkg::REG_C0_X: cx_reg[0] <= cfg_data;
                    qfpl_pkg::REG_C0_Y: cy_reg[0] <= cfg_data;
                    qfpl_pkg::REG_C1_X: cx_reg[1] <= cfg_data;
                    qfpl_pkg::REG_C1_Y: cy_reg[1] <= cfg_data;
                    qfpl_pkg::REG_C2_X: cx_reg[2] <= cfg_data;
                    qfpl_pkg::REG_C2_Y: cy_reg[2] <= cfg_data;
                    qfpl_pkg::REG_C3_X: cx_reg[3] <= cfg_data;
                    qfpl_pkg::REG_C3_Y: cy_reg[3] <= cfg_data;
                    default: ;
                endcase
                settle_reg <= qfpl_pkg::SETTLE_CYCLES;
            end
            else if (settle_reg != 3'd0)
            begin
                settle_reg <= settle_reg - 3'd1;
            end
        end
    end

    assign busy = (settle_reg != 3'd0);

    // squared distances to corner 0
    always_comb
    begin
        for (int i = 1; i < 4; i++)
        begin
            d2_next[i] = QW'($signed({1'b0, cx_reg[i]}) - $signed({1'b0, cx_reg[0]}))
                       * QW'($signed({1'b0, cx_reg[i]}) - $signed({1'b0, cx_reg[0]}))
                       + QW'($signed({1'b0, cy_reg[i]}) - $signed({1'b0, cy_reg[0]}))
                       * QW'($signed({1'b0, cy_reg[i]}) - $signed({1'b0, cy_reg[0]}));
        end
    end

    // farthest corner becomes the diagonal, lowest index on ties
    always_comb
    begin
        best = '0;
        diag = 2'd0;
        for (int i = 1; i < 4; i++)
        begin
            if (d2_reg[i] > best)
            begin
                best = d2_reg[i];
                diag = 2'(i);
            end
        end
        for (int i = 0; i < 4; i++)
        begin
            ox[i] = cx_reg[i];
            oy[i] = cy_reg[i];
        end
        if (diag == 2'd1)
        begin
            ox[1] = cx_reg[2]; oy[1] = cy_reg[2];
            ox[2] = cx_reg[1]; oy[2] = cy_reg[1];
        end
        else if (diag == 2'd3)
        begin
            ox[2] = cx_reg[3]; oy[2] = cy_reg[3];
            ox[3] = cx_reg[2]; oy[3] = cy_reg[2];
        end
        sx_next = SW'(ox[0]) + SW'(ox[1]) + SW'(ox[2]) + SW'(ox[3]);
        sy_next = SW'(oy[0]) + SW'(oy[1]) + SW'(oy[2]) + SW'(oy[3]);
    end

    always_ff @(posedge clk)
    begin
        d2_reg <= d2_next;
        sx_reg <= sx_next;
        sy_reg <= sy_next;
        for (int i = 0; i < 4; i++)
        begin
            dx_reg[i] <= $signed({1'b0, ox[i], 2'b00}) - $signed({1'b0, sx_next});
            dy_reg[i] <= $signed({1'b0, oy[i], 2'b00}) - $signed({1'b0, sy_next});
        end
        for (int k = 0; k < 4; k++)
        begin
            pa_reg[k]  <= PW'(dx_reg[k]) * PW'(dy_reg[2'(k + 1)]);
            pb_reg[k]  <= PW'(dy_reg[k]) * PW'(dx_reg[2'(k + 1)]);
            det_reg[k] <= AW'(pa_reg[k]) - AW'(pb_reg[k]);
        end
    end

    assign sum_x = sx_reg;
    assign sum_y = sy_reg;
    assign dir_x = dx_reg;
    assign dir_y = dy_reg;
    assign det   = det_reg;

endmodule

[design/qfpl_front.sv]
// Front pipeline: relative point, dot/cross products, sector pick, scaled numerators.
module qfpl_front #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 8
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         in_valid,
    output logic                                         in_ready,
    input  logic [COORD_BITS-1:0]                        point_x,
    input  logic [COORD_BITS-1:0]                        point_y,
    input  logic [COORD_BITS+1:0]                        sum_x,
    input  logic [COORD_BITS+1:0]                        sum_y,
    input  logic signed [COORD_BITS+2:0]                 dir_x [4],
    input  logic signed [COORD_BITS+2:0]                 dir_y [4],
    input  logic signed [2*COORD_BITS+6:0]               det [4],
    output logic                                         out_valid,
    input  logic                                         out_ready,
    output logic signed [2*COORD_BITS+FRAC_BITS+16:0]    num_x,
    output logic signed [2*COORD_BITS+FRAC_BITS+16:0]    num_y,
    output logic [2*COORD_BITS+6:0]                      den,
    output qfpl_pkg::meta_t                              meta
);
    localparam int CW = COORD_BITS;
    localparam int DW = CW + 3;
    localparam int PW = 2 * DW;
    localparam int AW = PW + 1;
    localparam int XW = AW + 2;
    localparam int QB = FRAC_BITS + 7;
    localparam int NW = XW + QB + 1;
    localparam logic signed [NW-1:0] FULL_N = NW'(100 * (2 ** FRAC_BITS));
    localparam logic signed [AW-1:0] DOT_MIN = AW'(qfpl_pkg::DOT_LIMIT);

    logic [6:1] v_reg;
    logic [7:1] en;

    logic signed [DW-1:0] rx_reg, ry_reg;
    logic signed [PW-1:0] pxx_reg [4];
    logic signed [PW-1:0] pyy_reg [4];
    logic signed [PW-1:0] pxy_reg [4];
    logic signed [PW-1:0] pyx_reg [4];
    logic signed [AW-1:0] dot_reg [4];
    logic signed [AW-1:0] a_reg   [4];

    logic                 pass [4];
    logic signed [AW-1:0] sn   [4];
    logic signed [AW-1:0] tn   [4];
    logic                 done;
    logic                 fb_next;
    logic [1:0]           sel_next;
    logic signed [AW-1:0] sn_next, tn_next, dabs_next;

    logic signed [AW-1:0] sn_reg, tn_reg, d4_reg, d5_reg;
    qfpl_pkg::meta_t      m4_reg, m5_reg, m6_reg;
    logic signed [XW-1:0] xx_reg, xy_reg;
    logic signed [NW-1:0] nx_reg, ny_reg;
    logic [AW-1:0]        den_reg;

    always_comb
    begin
        en[7] = out_ready;
        for (int s = 6; s >= 1; s--)
        begin
            en[s] = !v_reg[s] || en[s + 1];
        end
    end
    assign in_ready = en[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[1]) v_reg[1] <= in_valid;
            for (int s = 2; s <= 6; s++)
            begin
                if (en[s]) v_reg[s] <= v_reg[s - 1];
            end
        end
    end

    // sector test and selection, first passing sector with zero det or non-negative s and t decides
    always_comb
    begin
        done      = 1'b0;
        fb_next   = 1'b1;
        sel_next  = 2'd0;
        sn_next   = '0;
        tn_next   = '0;
        dabs_next = '0;
        for (int k = 0; k < 4; k++)
        begin
            pass[k] = (dot_reg[k] >= DOT_MIN) && (dot_reg[2'(k + 1)] >= DOT_MIN);
            if (det[k][AW-1])
            begin
                sn[k] = a_reg[2'(k + 1)];
                tn[k] = -a_reg[k];
            end
            else
            begin
                sn[k] = -a_reg[2'(k + 1)];
                tn[k] = a_reg[k];
            end
        end
        for (int k = 0; k < 4; k++)
        begin
            if (!done && pass[k])
            begin
                if (det[k] == '0)
                begin
                    done = 1'b1;
                end
                else if (!sn[k][AW-1] && !tn[k][AW-1])
                begin
                    done      = 1'b1;
                    fb_next   = 1'b0;
                    sel_next  = 2'(k);
                    sn_next   = sn[k];
                    tn_next   = tn[k];
                    dabs_next = det[k][AW-1] ? -det[k] : det[k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            rx_reg <= $signed({1'b0, point_x, 2'b00}) - $signed({1'b0, sum_x});
            ry_reg <= $signed({1'b0, point_y, 2'b00}) - $signed({1'b0, sum_y});
        end
        if (en[2])
        begin
            for (int k = 0; k < 4; k++)
            begin
                pxx_reg[k] <= PW'(dir_x[k]) * PW'(rx_reg);
                pyy_reg[k] <= PW'(dir_y[k]) * PW'(ry_reg);
                pxy_reg[k] <= PW'(dir_x[k]) * PW'(ry_reg);
                pyx_reg[k] <= PW'(dir_y[k]) * PW'(rx_reg);
            end
        end
        if (en[3])
        begin
            for (int k = 0; k < 4; k++)
            begin
                dot_reg[k] <= AW'(pxx_reg[k]) + AW'(pyy_reg[k]);
                a_reg[k]   <= AW'(pxy_reg[k]) - AW'(pyx_reg[k]);
            end
        end
        if (en[4])
        begin
            sn_reg <= sn_next;
            tn_reg <= tn_next;
            d4_reg <= dabs_next;
            m4_reg <= '{sector: sel_next, fallback: fb_next};
        end
        if (en[5])
        begin
            // det * (1 +- s +- t), numerators over det
            xx_reg <= XW'(d4_reg)
                    + (qfpl_pkg::SGN_X_S_NEG[m4_reg.sector] ? -XW'(sn_reg) : XW'(sn_reg))
                    + (qfpl_pkg::SGN_X_T_NEG[m4_reg.sector] ? -XW'(tn_reg) : XW'(tn_reg));
            xy_reg <= XW'(d4_reg)
                    + (qfpl_pkg::SGN_Y_S_NEG[m4_reg.sector] ? -XW'(sn_reg) : XW'(sn_reg))
                    + (qfpl_pkg::SGN_Y_T_NEG[m4_reg.sector] ? -XW'(tn_reg) : XW'(tn_reg));
            d5_reg <= d4_reg;
            m5_reg <= m4_reg;
        end
        if (en[6])
        begin
            // round to nearest: (2*half*X + det) / (2*det)
            nx_reg  <= FULL_N * NW'(xx_reg) + NW'(d5_reg);
            ny_reg  <= FULL_N * NW'(xy_reg) + NW'(d5_reg);
            den_reg <= {d5_reg[AW-2:0], 1'b0};
            m6_reg  <= m5_reg;
        end
    end

    assign out_valid = v_reg[6];
    assign num_x     = nx_reg;
    assign num_y     = ny_reg;
    assign den       = den_reg;
    assign meta      = m6_reg;

endmodule

[design/qfpl_div.sv]
// Pipelined restoring divider (one quotient bit per stage) with saturation and output register.
module qfpl_div #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 8
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         in_valid,
    output logic                                         in_ready,
    input  logic signed [2*COORD_BITS+FRAC_BITS+16:0]    num_x,
    input  logic signed [2*COORD_BITS+FRAC_BITS+16:0]    num_y,
    input  logic [2*COORD_BITS+6:0]                      den,
    input  qfpl_pkg::meta_t                              meta,
    output logic                                         out_valid,
    input  logic                                         out_ready,
    output logic [FRAC_BITS+6:0]                         loc_x,
    output logic [FRAC_BITS+6:0]                         loc_y,
    output logic [1:0]                                   sector,
    output logic                                         fallback,
    output logic                                         clipped
);
    localparam int CW = COORD_BITS;
    localparam int AW = 2 * (CW + 3) + 1;
    localparam int QB = FRAC_BITS + 7;
    localparam int NW = AW + 2 + QB + 1;
    localparam int RW = NW - 1;
    localparam int LAST = QB + 1;
    localparam logic [QB-1:0] FULL = QB'(100 * (2 ** FRAC_BITS));
    localparam logic [QB-1:0] HALF = QB'(50 * (2 ** FRAC_BITS));

    logic [LAST:0]   v_reg;
    logic [LAST+1:0] en;

    logic [RW-1:0]        rx_reg [0:QB];
    logic [RW-1:0]        ry_reg [0:QB];
    logic [QB-1:0]        qx_reg [0:QB];
    logic [QB-1:0]        qy_reg [0:QB];
    logic [AW-1:0]        d_reg  [0:QB];
    qfpl_pkg::meta_t      m_reg  [0:QB];
    qfpl_pkg::range_t     f_reg  [0:QB];

    logic [RW-1:0]        dtop;
    logic                 neg_x, neg_y, hi_x, hi_y;
    logic                 big_x, big_y;

    logic [QB-1:0]        lx_reg, ly_reg;
    logic [1:0]           sec_reg;
    logic                 fb_reg, clip_reg;

    always_comb
    begin
        en[LAST+1] = out_ready;
        for (int s = LAST; s >= 0; s--)
        begin
            en[s] = !v_reg[s] || en[s + 1];
        end
    end
    assign in_ready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0]) v_reg[0] <= in_valid;
            for (int s = 1; s <= LAST; s++)
            begin
                if (en[s]) v_reg[s] <= v_reg[s - 1];
            end
        end
    end

    // range check: quotient below zero or at/above 2^QB
    always_comb
    begin
        dtop  = RW'({den, {QB{1'b0}}});
        neg_x = num_x[NW-1];
        neg_y = num_y[NW-1];
        hi_x  = !neg_x && (num_x[RW-1:0] >= dtop);
        hi_y  = !neg_y && (num_y[RW-1:0] >= dtop);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            rx_reg[0] <= (neg_x || hi_x) ? '0 : num_x[RW-1:0];
            ry_reg[0] <= (neg_y || hi_y) ? '0 : num_y[RW-1:0];
            qx_reg[0] <= '0;
            qy_reg[0] <= '0;
            d_reg[0]  <= den;
            m_reg[0]  <= meta;
            f_reg[0]  <= '{neg_x: neg_x, hi_x: hi_x, neg_y: neg_y, hi_y: hi_y};
        end
    end

    for (genvar s = 1; s <= QB; s++)
    begin : g_step
        localparam int B = QB - s;
        logic [RW-1:0] dsh;
        assign dsh = RW'(d_reg[s-1]) << B;
        always_ff @(posedge clk)
        begin
            if (en[s])
            begin
                if (rx_reg[s-1] >= dsh)
                begin
                    rx_reg[s]    <= rx_reg[s-1] - dsh;
                    qx_reg[s]    <= qx_reg[s-1] | (QB'(1) << B);
                end
                else
                begin
                    rx_reg[s]    <= rx_reg[s-1];
                    qx_reg[s]    <= qx_reg[s-1];
                end
                if (ry_reg[s-1] >= dsh)
                begin
                    ry_reg[s]    <= ry_reg[s-1] - dsh;
                    qy_reg[s]    <= qy_reg[s-1] | (QB'(1) << B);
                end
                else
                begin
                    ry_reg[s]    <= ry_reg[s-1];
                    qy_reg[s]    <= qy_reg[s-1];
                end
                d_reg[s] <= d_reg[s-1];
                m_reg[s] <= m_reg[s-1];
                f_reg[s] <= f_reg[s-1];
            end
        end
    end

    assign big_x = f_reg[QB].hi_x || (qx_reg[QB] > FULL);
    assign big_y = f_reg[QB].hi_y || (qy_reg[QB] > FULL);

    // saturate to 0..100 percent, fallback gives the centre
    always_ff @(posedge clk)
    begin
        if (en[LAST])
        begin
            fb_reg <= m_reg[QB].fallback;
            if (m_reg[QB].fallback)
            begin
                lx_reg   <= HALF;
                ly_reg   <= HALF;
                sec_reg  <= 2'd0;
                clip_reg <= 1'b0;
            end
            else
            begin
                lx_reg   <= f_reg[QB].neg_x ? '0 : (big_x ? FULL : qx_reg[QB]);
                ly_reg   <= f_reg[QB].neg_y ? '0 : (big_y ? FULL : qy_reg[QB]);
                sec_reg  <= m_reg[QB].sector;
                clip_reg <= f_reg[QB].neg_x || big_x || f_reg[QB].neg_y || big_y;
            end
        end
    end

    assign out_valid = v_reg[LAST];
    assign loc_x     = lx_reg;
    assign loc_y     = ly_reg;
    assign sector    = sec_reg;
    assign fallback  = fb_reg;
    assign clipped   = clip_reg;

endmodule

[design/quad_field_point_locator.sv]
// Top level of the quad field point locator: config, geometry, front pipeline, divider.
//
//  channel  | handshake           | word
//  ---------+---------------------+--------------------------------------------
//  point in | pt_valid/pt_ready   | point_x, point_y
//  loc out  | loc_valid/loc_ready | loc_x, loc_y, sector, fallback, clipped
//  config   | cfg_write_en        | cfg_index, cfg_data (no wait, no read-back)
//
// One word per cycle sustained while loc_ready stays high and the geometry is
// settled. The pipeline has 6 front stages plus FRAC_BITS+9 divider/output
// stages; the depth comes from the restoring divider, one quotient bit per stage.
// After reset and after every config write the geometry pipeline has to
// settle; pt_ready stays low during that time.
// Each stage holds when the one after it is full and stalled; bubbles are
// squeezed out, so a stall on loc_ready neither drops nor repeats a word.
module quad_field_point_locator #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 8
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write_en,
    input  logic [2:0]                cfg_index,
    input  logic [COORD_BITS-1:0]     cfg_data,
    input  logic                      pt_valid,
    output logic                      pt_ready,
    input  logic [COORD_BITS-1:0]     point_x,
    input  logic [COORD_BITS-1:0]     point_y,
    output logic                      loc_valid,
    input  logic                      loc_ready,
    output logic [FRAC_BITS+6:0]      loc_x,
    output logic [FRAC_BITS+6:0]      loc_y,
    output logic [1:0]                sector,
    output logic                      fallback,
    output logic                      clipped
);
    localparam int CW = COORD_BITS;
    localparam int DW = CW + 3;
    localparam int AW = 2 * DW + 1;
    localparam int NW = AW + 2 + FRAC_BITS + 7 + 1;
    localparam logic [FRAC_BITS+6:0] FULL = (FRAC_BITS+7)'(100 * (2 ** FRAC_BITS));

    logic                  geom_busy;
    logic [CW+1:0]         sum_x, sum_y;
    logic signed [DW-1:0]  dir_x [4];
    logic signed [DW-1:0]  dir_y [4];
    logic signed [AW-1:0]  det   [4];

    logic                  front_ready;
    logic                  mid_valid, mid_ready;
    logic signed [NW-1:0]  num_x, num_y;
    logic [AW-1:0]         den;
    qfpl_pkg::meta_t       meta;

    // corner registers; derived geometry is config-static
    qfpl_geom #(
        .COORD_BITS (COORD_BITS)
    ) u_geom (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .busy         (geom_busy),
        .sum_x        (sum_x),
        .sum_y        (sum_y),
        .dir_x        (dir_x),
        .dir_y        (dir_y),
        .det          (det)
    );

    // no points taken while geometry settles
    assign pt_ready = front_ready && !geom_busy;

    qfpl_front #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pt_valid && !geom_busy),
        .in_ready  (front_ready),
        .point_x   (point_x),
        .point_y   (point_y),
        .sum_x     (sum_x),
        .sum_y     (sum_y),
        .dir_x     (dir_x),
        .dir_y     (dir_y),
        .det       (det),
        .out_valid (mid_valid),
        .out_ready (mid_ready),
        .num_x     (num_x),
        .num_y     (num_y),
        .den       (den),
        .meta      (meta)
    );

    qfpl_div #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mid_valid),
        .in_ready  (mid_ready),
        .num_x     (num_x),
        .num_y     (num_y),
        .den       (den),
        .meta      (meta),
        .out_valid (loc_valid),
        .out_ready (loc_ready),
        .loc_x     (loc_x),
        .loc_y     (loc_y),
        .sector    (sector),
        .fallback  (fallback),
        .clipped   (clipped)
    );

    // fallback word is the centre with sector 0 and no clipping
    a_fallback_word: assert property (@(posedge clk) disable iff (!rst_n)
        loc_valid && fallback |-> sector == 2'd0 && !clipped)
        else $error("fallback word carries sector or clip");

    // coordinates never leave the saturated range
    a_loc_range: assert property (@(posedge clk) disable iff (!rst_n)
        loc_valid |-> loc_x <= FULL && loc_y <= FULL)
        else $error("location out of range");

    // a config write blocks point intake on the next cycle
    a_settle_block: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write_en |=> !pt_ready)
        else $error("point accepted while geometry settles");

endmodule

[verif/tb_top.sv]
// Testbench for the quad field point locator: scoreboard, stimulus tasks, idling.
`timescale 1ns / 1ps

module tb_top;

    // ------------------------------------------------------------------
    // Clock, reset, DUT ports
    // ------------------------------------------------------------------
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write_en = 1'b0;
    logic [2:0]  cfg_index = qfpl_pkg::REG_C0_X;
    logic [11:0] cfg_data = '0;
    logic        pt_valid = 1'b0;
    logic        pt_ready;
    logic [11:0] point_x = '0;
    logic [11:0] point_y = '0;
    logic        loc_valid;
    logic        loc_ready = 1'b0;
    logic [14:0] loc_x;
    logic [14:0] loc_y;
    logic [1:0]  sector;
    logic        fallback;
    logic        clipped;

    always #5 clk = ~clk;

    quad_field_point_locator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pt_valid     (pt_valid),
        .pt_ready     (pt_ready),
        .point_x      (point_x),
        .point_y      (point_y),
        .loc_valid    (loc_valid),
        .loc_ready    (loc_ready),
        .loc_x        (loc_x),
        .loc_y        (loc_y),
        .sector       (sector),
        .fallback     (fallback),
        .clipped      (clipped)
    );

    // ------------------------------------------------------------------
    // Shared state
    // ------------------------------------------------------------------
    typedef struct {
        logic [14:0] lx;
        logic [14:0] ly;
        logic [1:0]  sec;
        logic        fb;
        logic        clip;
    } loc_word_t;

    typedef int quad_t [8];

    loc_word_t loc_expected [$];   // predicted words, oldest first
    int        corner_reg [8];     // mirror of the corner registers
    int        error_count = 0;
    bit        calm_mode   = 0;    // no idling on either side
    int        hold_request = 0;   // long receiver hold-off, cycles

    // ------------------------------------------------------------------
    // Predictor: reorder corners, fan sectors, solve s/t, scale to percent
    // ------------------------------------------------------------------
    function automatic longint floor_quot(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0)
            q = q - 1;
        return q;
    endfunction

    function automatic logic [14:0] scale_pct(int sc, int tc, longint sn, longint tn,
                                              longint det, inout logic clip);
        longint num;
        longint v;
        num = longint'(50 * 256) * (det + sc * sn + tc * tn);
        v = floor_quot(2 * num + det, 2 * det);
        if (v < 0)
        begin
            v = 0;
            clip = 1'b1;
        end
        if (v > 100 * 256)
        begin
            v = 100 * 256;
            clip = 1'b1;
        end
        return v[14:0];
    endfunction

    function automatic loc_word_t locate_point(int px, int py);
        longint cx [4], cy [4], ox [4], oy [4], dx [4], dy [4];
        longint sumx, sumy, rx, ry, best, ex, ey, d2;
        longint dot1, dot2, det, sn, tn;
        int diag, j;
        logic clip;
        loc_word_t w;
        sumx = 0; sumy = 0; best = 0; diag = 0;
        w.lx = 15'(50 * 256); w.ly = 15'(50 * 256);
        w.sec = 2'd0; w.fb = 1'b1; w.clip = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            cx[i] = corner_reg[2 * i];
            cy[i] = corner_reg[2 * i + 1];
        end
        // farthest from corner 0 wins, ties keep the lower index
        for (int i = 1; i < 4; i++)
        begin
            ex = cx[i] - cx[0];
            ey = cy[i] - cy[0];
            d2 = ex * ex + ey * ey;
            if (d2 > best)
            begin
                best = d2;
                diag = i;
            end
        end
        for (int i = 0; i < 4; i++)
        begin
            ox[i] = cx[i];
            oy[i] = cy[i];
        end
        if (diag == 1)
        begin
            ox[1] = cx[2]; oy[1] = cy[2]; ox[2] = cx[1]; oy[2] = cy[1];
        end
        else if (diag == 3)
        begin
            ox[2] = cx[3]; oy[2] = cy[3]; ox[3] = cx[2]; oy[3] = cy[2];
        end
        for (int i = 0; i < 4; i++)
        begin
            sumx += ox[i];
            sumy += oy[i];
        end
        for (int i = 0; i < 4; i++)
        begin
            dx[i] = 4 * ox[i] - sumx;
            dy[i] = 4 * oy[i] - sumy;
        end
        rx = 4 * longint'(px) - sumx;
        ry = 4 * longint'(py) - sumy;
        for (int k = 0; k < 4; k++)
        begin
            j = (k + 1) & 3;
            dot1 = dx[k] * rx + dy[k] * ry;
            dot2 = dx[j] * rx + dy[j] * ry;
            if (dot1 < qfpl_pkg::DOT_LIMIT || dot2 < qfpl_pkg::DOT_LIMIT)
                continue;
            det = dx[k] * dy[j] - dy[k] * dx[j];
            if (det == 0)
                return w;
            sn = dy[j] * rx - dx[j] * ry;
            tn = dx[k] * ry - dy[k] * rx;
            if (det < 0)
            begin
                det = -det; sn = -sn; tn = -tn;
            end
            if (sn < 0 || tn < 0)
                continue;
            clip = 1'b0;
            w.lx = scale_pct(qfpl_pkg::SGN_X_S_NEG[k] ? -1 : 1,
                             qfpl_pkg::SGN_X_T_NEG[k] ? -1 : 1,
                             sn, tn, det, clip);
            w.ly = scale_pct(qfpl_pkg::SGN_Y_S_NEG[k] ? -1 : 1,
                             qfpl_pkg::SGN_Y_T_NEG[k] ? -1 : 1,
                             sn, tn, det, clip);
            w.sec = 2'(k);
            w.fb = 1'b0;
            w.clip = clip;
            return w;
        end
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Receiver: idling bursts, long hold-off, and the result check
    // ------------------------------------------------------------------
    int        rx_stall = 0;
    loc_word_t want;

    always @(posedge clk)
    begin
        if (loc_valid && loc_ready)
        begin
            if (loc_expected.size() == 0)
            begin
                $display("%0t: unexpected word loc_x=%0d loc_y=%0d sector=%0d fb=%0d clip=%0d",
                         $time, loc_x, loc_y, sector, fallback, clipped);
                error_count++;
            end
            else
            begin
                want = loc_expected.pop_front();
                if (loc_x !== want.lx)
                begin
                    $display("%0t: loc_x expected %0d actual %0d", $time, want.lx, loc_x);
                    error_count++;
                end
                if (loc_y !== want.ly)
                begin
                    $display("%0t: loc_y expected %0d actual %0d", $time, want.ly, loc_y);
                    error_count++;
                end
                if (sector !== want.sec)
                begin
                    $display("%0t: sector expected %0d actual %0d", $time, want.sec, sector);
                    error_count++;
                end
                if (fallback !== want.fb)
                begin
                    $display("%0t: fallback expected %0d actual %0d", $time, want.fb,
                             fallback);
                    error_count++;
                end
                if (clipped !== want.clip)
                begin
                    $display("%0t: clipped expected %0d actual %0d", $time, want.clip,
                             clipped);
                    error_count++;
                end
            end
        end
        // ready for the next edge
        if (hold_request > 0)
        begin
            rx_stall = hold_request;
            hold_request = 0;
        end
        if (rx_stall > 0)
        begin
            rx_stall--;
            loc_ready <= 1'b0;
        end
        else if (!calm_mode && $urandom_range(0, 5) == 0)
        begin
            rx_stall = $urandom_range(1, 17) - 1;
            loc_ready <= 1'b0;
        end
        else
            loc_ready <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Shared stimulus helpers (entered and left at a rising edge)
    // ------------------------------------------------------------------
    task automatic send_point(int px, int py);
        pt_valid <= 1'b1;
        point_x  <= 12'(px);
        point_y  <= 12'(py);
        do
            @(posedge clk);
        while (!pt_ready);
        loc_expected.push_back(locate_point(px & 12'hfff, py & 12'hfff));
        // sender gap after the accepted word
        if (!calm_mode && $urandom_range(0, 4) == 0)
        begin
            pt_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        pt_valid <= 1'b0;
        while (loc_expected.size() != 0)
            @(posedge clk);
        // settle margin beyond the pipeline depth
        repeat (40) @(posedge clk);
    endtask

    task automatic load_quad(quad_t q);
        wait_drained();
        for (int i = 0; i < 8; i++)
        begin
            cfg_write_en <= 1'b1;
            cfg_index    <= 3'(i);
            cfg_data     <= 12'(q[i]);
            corner_reg[i] = q[i] & 12'hfff;
            @(posedge clk);
        end
        cfg_write_en <= 1'b0;
    endtask

    function automatic int clamp12(int v);
        return (v < 0) ? 0 : (v > 4095) ? 4095 : v;
    endfunction

    // Roughly convex quad around a random centre, corners in shuffled order; one time in eight all corners are random
    function automatic quad_t make_quad(output int qx, output int qy, output int qr);
        quad_t q;
        int jx [4], jy [4], t;
        int sxs [4] = '{-1, 1, 1, -1};
        int sys [4] = '{-1, -1, 1, 1};
        int order [4] = '{0, 1, 2, 3};
        qx = $urandom_range(400, 3700);
        qy = $urandom_range(400, 3700);
        qr = $urandom_range(4, 600);
        for (int i = 0; i < 4; i++)
        begin
            jx[i] = $urandom_range(0, 2 * (qr / 3)) - qr / 3;
            jy[i] = $urandom_range(0, 2 * (qr / 3)) - qr / 3;
        end
        for (int i = 0; i < 4; i++)
        begin
            t = $urandom_range(0, 3);
            {order[i], order[t]} = {order[t], order[i]};
        end
        for (int i = 0; i < 4; i++)
        begin
            q[2 * i]     = clamp12(qx + sxs[order[i]] * qr + jx[i]);
            q[2 * i + 1] = clamp12(qy + sys[order[i]] * qr + jy[i]);
        end
        if ($urandom_range(0, 7) == 0)
            for (int i = 0; i < 8; i++)
                q[i] = $urandom_range(0, 4095);
        return q;
    endfunction

    task automatic random_points(int n, int qx, int qy, int qr);
        for (int i = 0; i < n; i++)
            if ($urandom_range(0, 9) < 7)
                send_point(clamp12(qx + $urandom_range(0, 4 * qr) - 2 * qr),
                           clamp12(qy + $urandom_range(0, 4 * qr) - 2 * qr));
            else
                send_point($urandom_range(0, 4095), $urandom_range(0, 4095));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_reset_corners();
        // all corners at the origin: no farther corner, zero determinant
        send_point(0, 0);
        send_point(4095, 4095);
        send_point(4095, 0);
    endtask

    task automatic test_directed();
        quad_t q;
        // corner 1 is diagonal: swap into place
        q = '{1000, 1000, 3000, 3000, 3000, 1000, 1000, 3000};
        load_quad(q);
        send_point(1000, 1000);
        send_point(3000, 3000);
        send_point(2000, 2000);
        send_point(2000, 1000);
        send_point(0, 0);
        send_point(4095, 4095);
        send_point(0, 4095);
        send_point(2999, 1001);
        // corner 3 is diagonal
        q = '{0, 0, 4095, 0, 0, 4095, 4095, 4095};
        load_quad(q);
        send_point(0, 0);
        send_point(4095, 4095);
        send_point(2048, 2048);
        send_point(4095, 0);
        // tied farthest corners: lower index becomes the diagonal
        q = '{0, 0, 3, 4, 4, 3, 1, 1};
        load_quad(q);
        send_point(2, 2);
        send_point(4095, 4095);
        // all corners collinear: degenerate determinant
        q = '{100, 100, 200, 200, 300, 300, 400, 400};
        load_quad(q);
        send_point(250, 250);
        send_point(4095, 0);
        // all corners at one far point
        q = '{4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095};
        load_quad(q);
        send_point(4095, 4095);
        send_point(0, 0);
    endtask

    task automatic test_random(int sets, int per_set);
        quad_t q;
        int qx, qy, qr;
        for (int s = 0; s < sets; s++)
        begin
            q = make_quad(qx, qy, qr);
            load_quad(q);
            random_points(per_set, qx, qy, qr);
        end
    endtask

    task automatic test_backpressure();
        quad_t q;
        int qx, qy, qr;
        q = make_quad(qx, qy, qr);
        load_quad(q);
        // receiver holds off while the sender keeps offering, so pt_ready drops
        hold_request = 300;
        random_points(80, qx, qy, qr);
        // sender pauses until every word is back
        wait_drained();
        random_points(40, qx, qy, qr);
    endtask

    task automatic test_full_rate();
        calm_mode = 1;
        test_random(4, 60);
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_corners();
        test_directed();
        test_backpressure();
        test_random(23, 50);
        test_full_rate();
        wait_drained();
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // run limit
    initial
    begin
        #20_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
